// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/pvhc_pkg.sv -----
// types and constants of the polyline voxel hit counter
package pvhc_pkg;
    localparam int PT_W    = 20;
    localparam int POS_W   = 40;
    localparam int PROD_W  = 56;
    localparam int SUM_W   = 60;
    localparam int VOX_W   = 28;
    localparam int QUO_W   = 25;
    localparam int REM_W   = 22;
    localparam int STEP_W  = 26;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [POS_W-1:0] STEP_ONE  = 40'sd16777216;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = 60'sd2147483648;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_SETUP, ST_DIV, ST_MUL, ST_SUM,
        ST_CHECK, ST_MEM_RD, ST_MEM_WR, ST_ADV, ST_DONE
    } t_state;
endpackage

// ----- src/polyline_voxel_hit_counter_unit.sv -----
// polyline voxel hit counter: segment walk, affine voxel map, count memory
// a read passes ST_READ then ST_DONE; a first point goes straight to ST_DONE
// other points run ST_SETUP, a bit-serial slope divide per axis, then the sample walk
// a sample: map rows x, y, z (multiply, sum), check, step, read-modify-write if counted
// one command at a time; busy stays high until the result beat, no stall path
// the next command is accepted in the result cycle; a clearing pass after reset holds busy
module polyline_voxel_hit_counter_unit #(
    parameter int VOL_X      = 128,
    parameter int VOL_Y      = 128,
    parameter int VOL_Z      = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic        i_first_point,
    input  logic [19:0] i_point_x,
    input  logic [19:0] i_point_y,
    input  logic [19:0] i_point_z,
    input  logic [6:0]  i_read_x,
    input  logic [6:0]  i_read_y,
    input  logic [5:0]  i_read_z,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [15:0] o_count_value,
    output logic [15:0] o_voxels_marked,
    output logic        o_skipped_out_of_range,
    output logic [15:0] o_max_count
);
    `include "assert_macros.svh"

    localparam int XB     = $clog2(VOL_X);
    localparam int YB     = $clog2(VOL_Y);
    localparam int ZB     = $clog2(VOL_Z);
    localparam int ADDR_W = XB + YB + ZB;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam logic [9:0] VX10 = 10'(VOL_X);
    localparam logic [9:0] VY10 = 10'(VOL_Y);
    localparam logic [9:0] VZ10 = 10'(VOL_Z);

    // state machine
    pvhc_pkg::t_state r_state, n_state;

    // configuration
    logic [63:0] r_map [3];
    logic [7:0]  r_size_x, r_size_y;
    logic [6:0]  r_size_z;

    // command beat
    logic                        r_cmd, r_rd_ok;
    logic [ADDR_W-1:0]           r_rd_addr;
    logic signed [pvhc_pkg::PT_W-1:0] r_pt   [3];
    logic signed [pvhc_pkg::PT_W-1:0] r_prev [3];

    // segment setup and slope divider
    logic [1:0]                        r_k, r_j;
    logic [pvhc_pkg::PT_W-1:0]         r_mag [3];
    logic [2:0]                        r_neg;
    logic [pvhc_pkg::PT_W-1:0]         r_adk;
    logic [pvhc_pkg::REM_W-1:0]        r_rem;
    logic [pvhc_pkg::QUO_W-1:0]        r_quo;
    logic [4:0]                        r_bit;
    logic signed [pvhc_pkg::STEP_W-1:0] r_step [3];

    // walk position in q.24 mm
    logic signed [pvhc_pkg::POS_W-1:0] r_p [3];
    logic signed [pvhc_pkg::POS_W-1:0] r_end_k;

    // affine map
    logic [1:0]                         r_row;
    logic signed [pvhc_pkg::PROD_W-1:0] r_prod [3];
    logic signed [pvhc_pkg::VOX_W-1:0]  r_vox [3];

    // marking state
    logic [XB-1:0]         r_last_x;
    logic [YB-1:0]         r_last_y;
    logic [ZB-1:0]         r_last_z;
    logic                  r_last_valid;
    logic [ADDR_W-1:0]     r_hit_addr;
    logic [COUNT_BITS-1:0] r_peak;
    logic [15:0]           r_marked;
    logic                  r_oor;
    logic [ADDR_W-1:0]     r_clr;

    // count memory
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;
    logic                  w_mem_we, w_mem_re;
    logic [ADDR_W-1:0]     w_mem_waddr, w_mem_raddr;
    logic [COUNT_BITS-1:0] w_mem_wdata;

    // result registers
    logic        r_out_valid;
    logic [15:0] r_out_count, r_out_marked, r_out_max;
    logic        r_out_oor;

    // ---------------- segment setup: deltas, dominant axis, ordering
    logic signed [pvhc_pkg::PT_W:0] w_d [3];
    logic [pvhc_pkg::PT_W-1:0]      w_ad [3];
    logic [1:0]                     w_k;
    logic                           w_swap;
    logic signed [pvhc_pkg::PT_W-1:0] w_s [3];
    logic signed [pvhc_pkg::PT_W-1:0] w_e_k;

    always_comb begin
        logic signed [pvhc_pkg::PT_W:0] v_abs;
        for (int j = 0; j < 3; j++) begin
            w_d[j] = 21'(r_pt[j]) - 21'(r_prev[j]);
            v_abs  = w_d[j][pvhc_pkg::PT_W] ? -w_d[j] : w_d[j];
            w_ad[j] = v_abs[pvhc_pkg::PT_W-1:0];
        end
        // ties go to x, then y
        if (w_ad[0] >= w_ad[1] && w_ad[0] >= w_ad[2]) begin
            w_k = 2'd0;
        end else if (w_ad[1] >= w_ad[2]) begin
            w_k = 2'd1;
        end else begin
            w_k = 2'd2;
        end
        w_swap = r_prev[w_k] > r_pt[w_k];
        for (int j = 0; j < 3; j++) begin
            w_s[j] = w_swap ? r_pt[j] : r_prev[j];
        end
        w_e_k = w_swap ? r_prev[w_k] : r_pt[w_k];
    end

    // ---------------- restoring divider step, one quotient bit a cycle
    logic                       w_div_ge;
    logic [pvhc_pkg::REM_W-1:0] w_rem_next;
    logic [pvhc_pkg::QUO_W-1:0] w_quo_next;
    logic [1:0]                 w_j_next;

    always_comb begin
        logic [pvhc_pkg::REM_W-1:0] v_rem;
        w_div_ge   = r_rem >= 22'(r_adk);
        v_rem      = w_div_ge ? r_rem - 22'(r_adk) : r_rem;
        w_rem_next = {v_rem[pvhc_pkg::REM_W-2:0], 1'b0};
        w_quo_next = {r_quo[pvhc_pkg::QUO_W-2:0], w_div_ge};
        w_j_next   = r_j + 2'd1;
    end

    // ---------------- affine map, rounding half up
    logic signed [pvhc_pkg::SUM_W-1:0] w_sum;
    logic signed [pvhc_pkg::PROD_W-1:0] w_prod [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_prod[j] = $signed(r_map[r_row][16*j +: 16]) * r_p[j];
        end
        w_sum = 60'(r_prod[0]) + 60'(r_prod[1]) + 60'(r_prod[2])
              + (60'($signed(r_map[r_row][63:48])) <<< 24) + pvhc_pkg::ROUND_HALF;
    end

    // ---------------- range check against the extent in use
    logic [9:0]  w_ext_x, w_ext_y, w_ext_z;
    logic        w_out_of_range, w_same_voxel;
    logic [ADDR_W-1:0] w_vox_addr;

    always_comb begin
        w_ext_x = (10'(r_size_x) < VX10) ? 10'(r_size_x) : VX10;
        w_ext_y = (10'(r_size_y) < VY10) ? 10'(r_size_y) : VY10;
        w_ext_z = (10'(r_size_z) < VZ10) ? 10'(r_size_z) : VZ10;
        w_out_of_range = r_vox[0][pvhc_pkg::VOX_W-1]
                       | r_vox[1][pvhc_pkg::VOX_W-1]
                       | r_vox[2][pvhc_pkg::VOX_W-1]
                       | (r_vox[0][26:0] >= 27'(w_ext_x))
                       | (r_vox[1][26:0] >= 27'(w_ext_y))
                       | (r_vox[2][26:0] >= 27'(w_ext_z));
        w_same_voxel = r_last_valid
                     && r_vox[0][XB-1:0] == r_last_x
                     && r_vox[1][YB-1:0] == r_last_y
                     && r_vox[2][ZB-1:0] == r_last_z;
        w_vox_addr = {r_vox[2][ZB-1:0], r_vox[1][YB-1:0], r_vox[0][XB-1:0]};
    end

    // ---------------- major-axis advance, last step clamped to the end
    logic signed [pvhc_pkg::POS_W-1:0] w_pk_step, w_pk_next;
    logic                              w_walk_more;

    always_comb begin
        w_pk_step   = r_p[r_k] + pvhc_pkg::STEP_ONE;
        w_pk_next   = (w_pk_step > r_end_k) ? r_end_k : w_pk_step;
        w_walk_more = w_pk_next < r_end_k;
    end

    // ---------------- read command decode
    logic              w_rd_ok;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [9:0]        w_rx10, w_ry10, w_rz10;

    always_comb begin
        w_rx10    = 10'(i_read_x);
        w_ry10    = 10'(i_read_y);
        w_rz10    = 10'(i_read_z);
        w_rd_ok   = (w_rx10 < VX10) && (w_ry10 < VY10) && (w_rz10 < VZ10);
        w_rd_addr = {w_rz10[ZB-1:0], w_ry10[YB-1:0], w_rx10[XB-1:0]};
    end

    // saturating increment of the stored count
    logic [COUNT_BITS-1:0] w_cnt_inc;
    assign w_cnt_inc = (&r_rdata) ? r_rdata : r_rdata + 1'b1;

    // ---------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pvhc_pkg::ST_CLEAR:  if (&r_clr) n_state = pvhc_pkg::ST_IDLE;
            pvhc_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_cmd == pvhc_pkg::CMD_READ) begin
                        n_state = pvhc_pkg::ST_READ;
                    end else if (i_first_point) begin
                        n_state = pvhc_pkg::ST_DONE;
                    end else begin
                        n_state = pvhc_pkg::ST_SETUP;
                    end
                end
            end
            pvhc_pkg::ST_READ:   n_state = pvhc_pkg::ST_DONE;
            pvhc_pkg::ST_SETUP: begin
                // zero-length segment samples nothing
                n_state = (w_ad[w_k] == '0) ? pvhc_pkg::ST_DONE : pvhc_pkg::ST_DIV;
            end
            pvhc_pkg::ST_DIV: begin
                if (r_bit == 5'd0 && r_j == 2'd2) n_state = pvhc_pkg::ST_MUL;
            end
            pvhc_pkg::ST_MUL:    n_state = pvhc_pkg::ST_SUM;
            pvhc_pkg::ST_SUM: begin
                n_state = (r_row == 2'd2) ? pvhc_pkg::ST_CHECK : pvhc_pkg::ST_MUL;
            end
            pvhc_pkg::ST_CHECK: begin
                if (w_out_of_range || w_same_voxel) begin
                    n_state = pvhc_pkg::ST_ADV;
                end else begin
                    n_state = pvhc_pkg::ST_MEM_RD;
                end
            end
            pvhc_pkg::ST_MEM_RD: n_state = pvhc_pkg::ST_MEM_WR;
            pvhc_pkg::ST_MEM_WR: n_state = pvhc_pkg::ST_ADV;
            pvhc_pkg::ST_ADV: begin
                n_state = w_walk_more ? pvhc_pkg::ST_MUL : pvhc_pkg::ST_DONE;
            end
            pvhc_pkg::ST_DONE:   n_state = pvhc_pkg::ST_IDLE;
            default:             n_state = pvhc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs and memory port
    always_comb begin
        busy        = 1'b1;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_waddr = r_hit_addr;
        w_mem_raddr = r_hit_addr;
        w_mem_wdata = w_cnt_inc;
        case (r_state)
            pvhc_pkg::ST_IDLE:   busy = 1'b0;
            pvhc_pkg::ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr;
                w_mem_wdata = '0;
            end
            pvhc_pkg::ST_READ: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = r_rd_addr;
            end
            pvhc_pkg::ST_MEM_RD: w_mem_re = 1'b1;
            pvhc_pkg::ST_MEM_WR: w_mem_we = 1'b1;
            default: begin
            end
        endcase
    end

    // ---------------- count memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= mem[w_mem_raddr];
        end
    end

    // ---------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pvhc_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_map[0]     <= 64'd256;
            r_map[1]     <= 64'd16777216;
            r_map[2]     <= 64'd1099511627776;
            r_size_x     <= 8'd128;
            r_size_y     <= 8'd128;
            r_size_z     <= 7'd64;
            r_prev[0]    <= '0;
            r_prev[1]    <= '0;
            r_prev[2]    <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_z     <= '0;
            r_last_valid <= 1'b0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == pvhc_pkg::ST_DONE);
            if (r_state == pvhc_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    pvhc_pkg::CFG_MAP_X:  r_map[0] <= i_cfg_wdata;
                    pvhc_pkg::CFG_MAP_Y:  r_map[1] <= i_cfg_wdata;
                    pvhc_pkg::CFG_MAP_Z:  r_map[2] <= i_cfg_wdata;
                    pvhc_pkg::CFG_SIZE_X: r_size_x <= i_cfg_wdata[7:0];
                    pvhc_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_wdata[7:0];
                    pvhc_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_wdata[6:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == pvhc_pkg::ST_CHECK) begin
                if (w_out_of_range) begin
                    // next in-range voxel always counts
                    r_last_valid <= 1'b0;
                end else if (!w_same_voxel) begin
                    r_last_x     <= r_vox[0][XB-1:0];
                    r_last_y     <= r_vox[1][YB-1:0];
                    r_last_z     <= r_vox[2][ZB-1:0];
                    r_last_valid <= 1'b1;
                end
            end
            if (r_state == pvhc_pkg::ST_MEM_WR && w_cnt_inc > r_peak) begin
                r_peak <= w_cnt_inc;
            end
            if (r_state == pvhc_pkg::ST_DONE && r_cmd == pvhc_pkg::CMD_POINT) begin
                r_prev <= r_pt;
            end
        end
    end

    // ---------------- datapath registers
    always_ff @(posedge i_clk) begin
        logic [31:0] v_cnt32;
        logic [31:0] v_peak32;
        v_cnt32  = 32'(r_rdata);
        v_peak32 = 32'(r_peak);
        case (r_state)
            pvhc_pkg::ST_IDLE: begin
                r_cmd      <= i_cmd;
                r_rd_ok    <= w_rd_ok;
                r_rd_addr  <= w_rd_addr;
                r_pt[0]    <= i_point_x;
                r_pt[1]    <= i_point_y;
                r_pt[2]    <= i_point_z;
                r_marked   <= '0;
                r_oor      <= 1'b0;
            end
            pvhc_pkg::ST_SETUP: begin
                r_k     <= w_k;
                r_adk   <= w_ad[w_k];
                r_end_k <= 40'(w_e_k) <<< 16;
                for (int j = 0; j < 3; j++) begin
                    r_mag[j] <= w_ad[j];
                    r_neg[j] <= w_d[j][pvhc_pkg::PT_W] ^ w_swap;
                    r_p[j]   <= 40'(w_s[j]) <<< 16;
                end
                r_j   <= 2'd0;
                r_bit <= 5'd24;
                r_quo <= '0;
                r_rem <= 22'(w_ad[0]);
                r_row <= 2'd0;
            end
            pvhc_pkg::ST_DIV: begin
                if (r_bit == 5'd0) begin
                    r_step[r_j] <= r_neg[r_j] ? -$signed(26'(w_quo_next))
                                              : $signed(26'(w_quo_next));
                    r_j   <= w_j_next;
                    r_bit <= 5'd24;
                    r_quo <= '0;
                    r_rem <= (r_j == 2'd2) ? '0 : 22'(r_mag[w_j_next]);
                end else begin
                    r_bit <= r_bit - 5'd1;
                    r_quo <= w_quo_next;
                    r_rem <= w_rem_next;
                end
            end
            pvhc_pkg::ST_MUL: begin
                r_prod <= w_prod;
            end
            pvhc_pkg::ST_SUM: begin
                r_vox[r_row] <= w_sum[pvhc_pkg::SUM_W-1:32];
                r_row        <= (r_row == 2'd2) ? 2'd0 : r_row + 2'd1;
            end
            pvhc_pkg::ST_CHECK: begin
                r_hit_addr <= w_vox_addr;
                if (w_out_of_range) r_oor <= 1'b1;
            end
            pvhc_pkg::ST_MEM_WR: begin
                if (r_marked != 16'hFFFF) r_marked <= r_marked + 16'd1;
            end
            pvhc_pkg::ST_ADV: begin
                for (int j = 0; j < 3; j++) begin
                    if (2'(j) == r_k) begin
                        r_p[j] <= w_pk_next;
                    end else begin
                        r_p[j] <= r_p[j] + 40'(r_step[j]);
                    end
                end
            end
            pvhc_pkg::ST_DONE: begin
                r_out_count  <= (r_cmd == pvhc_pkg::CMD_READ && r_rd_ok)
                              ? v_cnt32[15:0] : 16'd0;
                r_out_marked <= r_marked;
                r_out_oor    <= r_oor;
                r_out_max    <= v_peak32[15:0];
            end
            default: begin
            end
        endcase
    end

    assign o_strobe               = r_out_valid;
    assign o_count_value          = r_out_count;
    assign o_voxels_marked        = r_out_marked;
    assign o_skipped_out_of_range = r_out_oor;
    assign o_max_count            = r_out_max;

    // ---------------- assertions
    `ASSERT_ALWAYS(a_beat_when_idle, i_clk, i_rst_n, o_strobe |-> !busy,
        "result beat while busy")
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy,
        "accepted command did not raise busy")
    `ASSERT_ALWAYS(a_mem_write_src, i_clk, i_rst_n,
        w_mem_we |-> (r_state == pvhc_pkg::ST_MEM_WR || r_state == pvhc_pkg::ST_CLEAR),
        "count memory written outside update or clear")
    `ASSERT_ALWAYS(a_peak_monotonic, i_clk, i_rst_n,
        $past(i_rst_n) |-> (r_peak >= $past(r_peak)), "peak count decreased")
endmodule
